[sv/wrs_pkg.sv]
// Package for the weighted random selector.
// Holds the fixed field widths and the status codes; no dependencies.
package wrs_pkg;

    localparam int ITEM_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED     = 2'd0,
        STATUS_REJECTED  = 2'd1,
        STATUS_SAMPLED   = 2'd2,
        STATUS_ZERO_TOTAL = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

endpackage

[sv/wrs_if.sv]
// Request and response channel interfaces of the weighted random selector.
// Depends on wrs_pkg for the field widths.
interface wrs_req_if;
    import wrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ITEM_W-1:0]   item_index;
    logic [WEIGHT_W-1:0] weight;
    logic [WORD_W-1:0]   random_word;

    modport source (output valid, cmd, item_index, weight, random_word, input ready);
    modport sink   (input valid, cmd, item_index, weight, random_word, output ready);
endinterface

interface wrs_rsp_if;
    import wrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0]   chosen_index;
    logic [STATUS_W-1:0] status;

    modport source (output valid, chosen_index, status, input ready);
    modport sink   (input valid, chosen_index, status, output ready);
endinterface

[sv/wrs_table.sv]
// Entry table: a synchronous memory of item index and weight pairs.
// One write port, one read port with registered read data; uses wrs_pkg.
module wrs_table #(
    parameter int ENTRIES = 16,
    parameter int W_BITS  = 16,
    parameter int ADDR_W  = 4
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [wrs_pkg::ITEM_W-1:0] wr_item,
    input  logic [W_BITS-1:0]         wr_weight,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [wrs_pkg::ITEM_W-1:0] rd_item,
    output logic [W_BITS-1:0]         rd_weight
);
    import wrs_pkg::*;

    logic [ITEM_W-1:0] mem_item   [ENTRIES];
    logic [W_BITS-1:0] mem_weight [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_item[wr_addr]   <= wr_item;
            mem_weight[wr_addr] <= wr_weight;
        end
        if (rd_en)
        begin
            rd_item   <= mem_item[rd_addr];
            rd_weight <= mem_weight[rd_addr];
        end
    end

endmodule

[sv/wrs_mod.sv]
// Bit-serial modulo unit: reduces a 32-bit word by a divisor, one bit a cycle.
// Restoring remainder recurrence; uses wrs_pkg for the word width.
module wrs_mod #(
    parameter int TOT_W = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wrs_pkg::WORD_W-1:0] dividend,
    input  logic [TOT_W-1:0]          divisor,
    output logic                      done,
    output logic [TOT_W-1:0]          remainder
);
    import wrs_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [TOT_W-1:0]  rem_next;
    logic [TOT_W:0]    rem_ext;

    always_comb
    begin
        rem_ext = {rem_reg, dvd_reg[WORD_W-1]};
        if (rem_ext >= {1'b0, divisor})
        begin
            rem_next = TOT_W'(rem_ext - {1'b0, divisor});
        end
        else
        begin
            rem_next = rem_ext[TOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WORD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[sv/weighted_random_selector.sv]
// Weighted random selector (roulette-wheel selection), top level.
// Depends on wrs_pkg, wrs_if, wrs_table and wrs_mod.
//
// Items arrive on req and results leave on rsp, both valid/ready channels.
// An add item (cmd 0) appends an item index and a weight to the entry table
// and answers ADDED, or REJECTED when the table is full or the index is out
// of range. A sample item (cmd 1) reduces random_word modulo the running total
// of the weights and answers SAMPLED with the index of the first entry whose
// cumulative weight exceeds the residue, or ZERO_TOTAL with index zero.
// One item is in work at a time. An add, or a sample against a zero total,
// goes straight to the result state after acceptance. A sample first runs
// the bit-serial modulo unit (start plus 32 steps), then reads the table's
// entries in order through its read port, one entry per cycle, until the
// first hit, and then loads the result. The next item can be accepted in
// the cycle after the result is loaded.
// Results sit in an output register; when the receiver stalls, the finished
// result waits there and the block holds the next one until it is taken.
// Reset empties the table and clears the total; no clearing pass is needed.
module weighted_random_selector #(
    parameter int ENTRIES     = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    wrs_req_if.sink   req,
    wrs_rsp_if.source rsp
);
    import wrs_pkg::*;

    localparam int W_BITS = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int TOT_W  = W_BITS + ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV    = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    scan_addr_reg;
    logic                rd_pend_reg;
    logic [TOT_W-1:0]    running_reg;
    logic [ITEM_W-1:0]   res_index_reg;
    status_t             res_status_reg;
    logic                out_valid_reg;
    logic [ITEM_W-1:0]   out_index_reg;
    status_t             out_status_reg;

    logic                accept;
    logic                add_ok;
    logic                wr_en;
    logic                rd_en;
    logic [ITEM_W-1:0]   rd_item;
    logic [W_BITS-1:0]   rd_weight;
    logic [W_BITS-1:0]   add_weight;
    logic [TOT_W-1:0]    sum;
    logic                hit;
    logic                div_start;
    logic                div_done;
    logic [TOT_W-1:0]    residue;
    logic                out_load;

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign add_weight = req.weight[W_BITS-1:0];
    assign add_ok     = (count_reg != CNT_W'(ENTRIES))
                        && (32'(req.item_index) < 32'(ENTRIES));
    assign wr_en      = accept && (req.cmd == CMD_ADD) && add_ok;
    assign div_start  = accept && (req.cmd == CMD_SAMPLE) && (total_reg != '0);
    assign rd_en      = (state_reg == ST_SCAN) && (scan_addr_reg < count_reg);
    assign sum        = running_reg + TOT_W'(rd_weight);
    assign hit        = rd_pend_reg && (sum > residue);
    assign out_load   = (state_reg == ST_RESULT) && (!out_valid_reg || rsp.ready);

    wrs_table #(
        .ENTRIES (ENTRIES),
        .W_BITS  (W_BITS),
        .ADDR_W  (ADDR_W)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[ADDR_W-1:0]),
        .wr_item   (req.item_index),
        .wr_weight (add_weight),
        .rd_en     (rd_en),
        .rd_addr   (scan_addr_reg[ADDR_W-1:0]),
        .rd_item   (rd_item),
        .rd_weight (rd_weight)
    );

    wrs_mod #(
        .TOT_W (TOT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.random_word),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (residue)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = div_start ? ST_DIV : ST_RESULT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || (!rd_pend_reg && !rd_en))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + TOT_W'(add_weight);
            end
            if (state_reg == ST_SCAN)
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
            end
            else
            begin
                rd_pend_reg   <= 1'b0;
                scan_addr_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_index_reg <= '0;
            if (req.cmd == CMD_ADD)
            begin
                res_status_reg <= add_ok ? STATUS_ADDED : STATUS_REJECTED;
            end
            else
            begin
                res_status_reg <= (total_reg != '0) ? STATUS_SAMPLED : STATUS_ZERO_TOTAL;
            end
        end
        if (state_reg == ST_SCAN)
        begin
            if (hit)
            begin
                res_index_reg <= rd_item;
            end
            else if (rd_pend_reg)
            begin
                running_reg <= sum;
            end
        end
        else
        begin
            running_reg <= '0;
        end
        if (out_load)
        begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.chosen_index = out_index_reg;
    assign rsp.status       = out_status_reg;

endmodule

[tb/selection_checker.sv]
`timescale 1ns / 100ps
// Checker for the weighted random selector: watches both channels, predicts each result
// from the items it sees accepted, and compares. Depends on wrs_pkg and wrs_if.
module selection_checker (
    input  logic clk,
    input  logic rst_n,
    wrs_req_if   req,
    wrs_rsp_if   rsp,
    output int   error_count,
    output int   outstanding
);
    import wrs_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int SUM_W       = 20;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [ITEM_W-1:0] chosen_index;
        status_t           status;
    } selection_t;

    logic [ITEM_W-1:0]   slot_item   [TABLE_DEPTH];
    logic [WEIGHT_W-1:0] slot_weight [TABLE_DEPTH];
    int                  slot_count;
    logic [SUM_W-1:0]    weight_sum;
    selection_t          expected_selections[$];

    function automatic selection_t predict_selection(cmd_t cmd, logic [ITEM_W-1:0] idx,
            logic [WEIGHT_W-1:0] w, logic [WORD_W-1:0] word);
        selection_t       sel;
        logic [WORD_W-1:0] divisor;
        logic [WORD_W-1:0] residue;
        logic [SUM_W:0]    running;
        sel.chosen_index = '0;
        if (cmd == CMD_ADD)
        begin
            if (slot_count >= TABLE_DEPTH || int'(idx) >= TABLE_DEPTH)
            begin
                sel.status = STATUS_REJECTED;
            end
            else
            begin
                slot_item[slot_count]   = idx;
                slot_weight[slot_count] = w;
                weight_sum              = weight_sum + SUM_W'(w);
                slot_count++;
                sel.status = STATUS_ADDED;
            end
        end
        else if (weight_sum == '0)
        begin
            sel.status = STATUS_ZERO_TOTAL;
        end
        else
        begin
            divisor    = WORD_W'(weight_sum);
            residue    = word % divisor;
            running    = '0;
            sel.status = STATUS_SAMPLED;
            for (int i = 0; i < slot_count; i++)
            begin
                running = running + (SUM_W + 1)'(slot_weight[i]);
                if (WORD_W'(running) > residue)
                begin
                    sel.chosen_index = slot_item[i];
                    break;
                end
            end
        end
        return sel;
    endfunction

    task automatic report_mismatch(string field, int expected_value, int actual_value);
        if (error_count < REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field, expected_value, actual_value);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        selection_t predicted;
        selection_t oldest;
        if (!rst_n)
        begin
            slot_count  = 0;
            weight_sum  = '0;
            error_count = 0;
            outstanding <= 0;
            expected_selections.delete();
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predicted = predict_selection(cmd_t'(req.cmd), req.item_index, req.weight,
                                              req.random_word);
                expected_selections.push_back(predicted);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_selections.size() == 0)
                begin
                    report_mismatch("unexpected result, status", -1, int'(rsp.status));
                end
                else
                begin
                    oldest = expected_selections.pop_front();
                    if (rsp.status !== oldest.status)
                        report_mismatch("status", int'(oldest.status), int'(rsp.status));
                    if (rsp.chosen_index !== oldest.chosen_index)
                        report_mismatch("chosen_index", int'(oldest.chosen_index),
                                        int'(rsp.chosen_index));
                end
            end
            outstanding <= expected_selections.size();
        end
    end

endmodule

[tb/weighted_random_selector_tb.sv]
`timescale 1ns / 100ps
// Weighted random selector testbench top: clock, reset, item stimulus, result back-pressure,
// watchdog and verdict. Needs wrs_pkg, wrs_if, weighted_random_selector and selection_checker.
module weighted_random_selector_tb;
    import wrs_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_WAIT     = 13;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 2000;

    logic clk;
    logic rst_n;
    int   error_count;
    int   outstanding;
    int   adds_sent;
    int   idle_cycles;
    bit   steady_sender;
    bit   steady_receiver;

    wrs_req_if req ();
    wrs_rsp_if rsp ();

    weighted_random_selector i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    selection_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(cmd_t cmd, logic [ITEM_W-1:0] idx, logic [WEIGHT_W-1:0] w,
            logic [WORD_W-1:0] word);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= cmd;
        req.item_index  <= idx;
        req.weight      <= w;
        req.random_word <= word;
        @(negedge clk);
        while (!req.ready) @(negedge clk);
        @(posedge clk);
        if (cmd == CMD_ADD)
            adds_sent++;
        if ($urandom_range(0, 39) == 0)
            steady_sender = !steady_sender;
    endtask

    task automatic send_random_item();
        cmd_t                cmd;
        logic [WEIGHT_W-1:0] w;
        logic [WORD_W-1:0]   word;
        if (adds_sent < TABLE_DEPTH)
            cmd = ($urandom_range(0, 5) == 0) ? CMD_ADD : CMD_SAMPLE;
        else
            cmd = ($urandom_range(0, 9) == 0) ? CMD_ADD : CMD_SAMPLE;
        case ($urandom_range(0, 5)) inside
            0:       w = '0;
            [1:2]:   w = WEIGHT_W'($urandom_range(1, 7));
            default: w = WEIGHT_W'($urandom);
        endcase
        word = ($urandom_range(0, 7) == 0) ? WORD_W'($urandom_range(0, 63)) : $urandom;
        send_item(cmd, ITEM_W'($urandom), w, word);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = CMD_ADD;
        req.item_index  = '0;
        req.weight      = '0;
        req.random_word = '0;
        adds_sent       = 0;
        steady_sender   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 4'd0, 16'h0000, 32'h0000_0000);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h0000_0000);
        send_item(CMD_ADD, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h0000_0000);
        send_item(CMD_SAMPLE, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 4'd5, 16'h0001, 32'h0000_0000);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h0000_FFFF);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h0000_FFFE);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 4'd10, 16'hAAAA, 32'h0000_0000);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'h5555_5555);
        send_item(CMD_ADD, 4'd3, 16'h5555, 32'h0000_0000);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'hAAAA_AAAA);

        repeat (RANDOM_ITEMS) send_random_item();

        while (adds_sent < TABLE_DEPTH + 2)
            send_item(CMD_ADD, ITEM_W'($urandom), WEIGHT_W'($urandom), $urandom);
        send_item(CMD_SAMPLE, 4'd0, 16'h0000, 32'hFFFF_FFFF);

        req.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int stall;
        rsp.ready       = 1'b0;
        steady_receiver = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_receiver ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(negedge clk);
            while (!rsp.valid) @(negedge clk);
            @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                steady_receiver = !steady_receiver;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
